FILE: rtl/core/nsmt_pkg.sv
// Shared types, constants and codes for the n-shot modifier tracker.
package nsmt_pkg;

    localparam int MAX_SLOTS     = 4;
    localparam int DEF_NUM_SLOTS = 4;
    localparam int KEY_W         = 16;
    localparam int TIME_W        = 16;
    localparam int MASK_W        = 8;
    localparam int SHOT_W        = 4;
    localparam int COUNT_W       = 5;
    localparam int NUM_CANCEL    = 3;
    localparam int NUM_EXTRA     = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int IN_DATA_W     = 32;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = 16;

    localparam logic [63:0] RST_TRIGGER_KEYS = 64'd0;
    localparam logic [31:0] RST_MOD_MASKS    = 32'd134480130;
    localparam logic [15:0] RST_MAX_SHOTS    = 16'd4369;
    localparam logic [3:0]  RST_ROLL_FLAGS   = 4'd15;
    localparam logic [47:0] RST_CANCEL_KEYS  = 48'd0;
    localparam logic [31:0] RST_EXTRA_KEYS   = 32'd0;
    localparam logic [15:0] RST_TAP_WINDOW   = 16'd200;

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_HELD_UNUSED = 2'd1,
        PH_HELD_USED   = 2'd2,
        PH_QUEUED      = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_KEYS = 3'd0,
        CFG_MOD_MASKS    = 3'd1,
        CFG_MAX_SHOTS    = 3'd2,
        CFG_ROLL_FLAGS   = 3'd3,
        CFG_CANCEL_KEYS  = 3'd4,
        CFG_EXTRA_KEYS   = 3'd5,
        CFG_TAP_WINDOW   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [63:0] trigger_keys;
        logic [31:0] mod_masks;
        logic [15:0] max_shots;
        logic [3:0]  roll_flags;
        logic [47:0] cancel_keys;
        logic [31:0] extra_keys;
        logic [15:0] tap_window;
    } cfg_t;

    // Classified key event handed from the front end to the slot engine.
    typedef struct packed {
        logic                  pressed;
        logic                  cancel;
        logic                  ignored;
        logic [MAX_SLOTS-1:0]  hit;
        logic [TIME_W-1:0]     now;
    } evt_t;

endpackage

FILE: rtl/core/nsmt_front.sv
// Front end: classify each accepted key event against trigger, ignore and cancel keys.
module nsmt_front #(
    parameter int NUM_SLOTS = nsmt_pkg::DEF_NUM_SLOTS
) (
    input  nsmt_pkg::cfg_t                        cfg,
    input  logic [nsmt_pkg::KEY_W-1:0]            key_code,
    input  logic                                  key_pressed,
    input  logic                                  cancel_layer_active,
    input  logic [nsmt_pkg::TIME_W-1:0]           event_time,
    output nsmt_pkg::evt_t                        evt
);
    import nsmt_pkg::*;

    logic [MAX_SLOTS-1:0]  hit;
    logic [NUM_EXTRA-1:0]  extra_hit;
    logic [NUM_CANCEL-1:0] cancel_hit;

    always_comb
    begin
        hit = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            hit[s] = (cfg.trigger_keys[KEY_W*s +: KEY_W] == key_code);
        end
        for (int i = 0; i < NUM_EXTRA; i++)
        begin
            extra_hit[i] = (cfg.extra_keys[KEY_W*i +: KEY_W] == key_code);
        end
        for (int i = 0; i < NUM_CANCEL; i++)
        begin
            cancel_hit[i] = (cfg.cancel_keys[KEY_W*i +: KEY_W] == key_code);
        end
    end

    always_comb
    begin
        evt.pressed = key_pressed;
        // trigger keys of every slot count as ignored keys
        evt.ignored = (|hit) | (|extra_hit);
        evt.cancel  = cancel_layer_active & (|cancel_hit);
        evt.hit     = hit;
        evt.now     = event_time;
    end

endmodule

FILE: rtl/core/nsmt_queue.sv
// Short event queue between the classifier and the slot engine.
module nsmt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nsmt_pkg::evt_t  push_evt,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output nsmt_pkg::evt_t  head_evt
);
    import nsmt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    evt_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_evt   = mem_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

FILE: rtl/core/nsmt_back.sv
// Slot engine: apply each queued event to all slots and register the result beat.
module nsmt_back #(
    parameter int NUM_SLOTS = nsmt_pkg::DEF_NUM_SLOTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nsmt_pkg::cfg_t                     cfg,
    input  logic                               evt_valid,
    input  nsmt_pkg::evt_t                     evt,
    output logic                               evt_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nsmt_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import nsmt_pkg::*;

    phase_t              phase_reg [NUM_SLOTS];
    phase_t              phase_next [NUM_SLOTS];
    logic [COUNT_W-1:0]  count_reg [NUM_SLOTS];
    logic [COUNT_W-1:0]  count_next [NUM_SLOTS];
    logic [TIME_W-1:0]   ptime_reg [NUM_SLOTS];
    logic [TIME_W-1:0]   ptime_next [NUM_SLOTS];
    logic                seen_reg [NUM_SLOTS];
    logic                seen_next [NUM_SLOTS];
    logic [MASK_W-1:0]   reg_m [NUM_SLOTS];
    logic [MASK_W-1:0]   unreg_m [NUM_SLOTS];

    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic [MASK_W-1:0]       reg_all;
    logic [MASK_W-1:0]       unreg_all;

    // advance when the output register is free or being drained
    assign evt_pop  = evt_valid & (~out_valid_reg | m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    for (genvar s = 0; s < NUM_SLOTS; s++)
    begin : g_slot
        logic [MASK_W-1:0]  mask;
        logic [COUNT_W-1:0] limit;
        logic               roll;
        logic [TIME_W-1:0]  elapsed;

        assign mask    = cfg.mod_masks[MASK_W*s +: MASK_W];
        assign limit   = {cfg.max_shots[SHOT_W*s +: SHOT_W], 1'b0};
        assign roll    = cfg.roll_flags[s];
        assign elapsed = evt.now - ptime_reg[s];

        always_comb
        begin
            phase_next[s] = phase_reg[s];
            count_next[s] = count_reg[s];
            ptime_next[s] = ptime_reg[s];
            seen_next[s]  = seen_reg[s];
            reg_m[s]      = '0;
            unreg_m[s]    = '0;
            if (evt.hit[s])
            begin
                if (evt.pressed)
                begin
                    if (phase_reg[s] == PH_IDLE)
                    begin
                        reg_m[s] = mask;
                    end
                    phase_next[s] = PH_HELD_UNUSED;
                    count_next[s] = '0;
                    seen_next[s]  = roll;
                    ptime_next[s] = evt.now;
                end
                else if (phase_reg[s] == PH_HELD_UNUSED)
                begin
                    if (elapsed < cfg.tap_window)
                    begin
                        phase_next[s] = PH_QUEUED;
                    end
                    else
                    begin
                        phase_next[s] = PH_IDLE;
                        unreg_m[s]    = mask;
                    end
                end
                else if (phase_reg[s] == PH_HELD_USED)
                begin
                    phase_next[s] = PH_IDLE;
                    unreg_m[s]    = mask;
                end
            end
            else if (evt.pressed)
            begin
                // cancel first; a cancelled slot is idle for the rest of the beat
                if (evt.cancel && phase_next[s] != PH_IDLE)
                begin
                    phase_next[s] = PH_IDLE;
                    count_next[s] = '0;
                    seen_next[s]  = roll;
                    unreg_m[s]    = mask;
                end
                if (phase_next[s] == PH_QUEUED && !evt.ignored)
                begin
                    count_next[s] = count_next[s] + 1'b1;
                    seen_next[s]  = 1'b1;
                    if (count_next[s] == limit)
                    begin
                        phase_next[s] = PH_IDLE;
                        count_next[s] = '0;
                        seen_next[s]  = roll;
                        unreg_m[s]    = mask;
                    end
                end
                if (phase_next[s] == PH_HELD_UNUSED)
                begin
                    seen_next[s] = 1'b1;
                end
            end
            else if (!evt.ignored)
            begin
                if (phase_reg[s] == PH_HELD_UNUSED)
                begin
                    if (seen_reg[s])
                    begin
                        phase_next[s] = PH_HELD_USED;
                    end
                end
                else if (phase_reg[s] == PH_QUEUED)
                begin
                    if (seen_reg[s])
                    begin
                        count_next[s] = count_reg[s] + 1'b1;
                    end
                    if (count_next[s] == limit)
                    begin
                        phase_next[s] = PH_IDLE;
                        count_next[s] = '0;
                        seen_next[s]  = roll;
                        unreg_m[s]    = mask;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                phase_reg[s] <= PH_IDLE;
                count_reg[s] <= '0;
                ptime_reg[s] <= '0;
                seen_reg[s]  <= 1'b0;
            end
            else if (evt_pop)
            begin
                phase_reg[s] <= phase_next[s];
                count_reg[s] <= count_next[s];
                ptime_reg[s] <= ptime_next[s];
                seen_reg[s]  <= seen_next[s];
            end
        end
    end

    always_comb
    begin
        reg_all   = '0;
        unreg_all = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            reg_all   = reg_all | reg_m[s];
            unreg_all = unreg_all | unreg_m[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (evt_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_pop)
        begin
            out_data_reg <= {unreg_all, reg_all};
        end
    end

endmodule

FILE: rtl/core/n_shot_modifier_tracker_top.sv
// Top level of the n-shot modifier tracker: configuration registers, front end, queue, slot engine.
// A key event passes through the event queue, and its result beat is held in an output register.
// Throughput: one key event per cycle unless the queue is full; all slots update together.
// A two-entry event queue lets the input side run on while the output beat is stalled.
// Reset (rst_n low, asynchronous): all slots up and idle with zero counts and times,
// queue and output empty, configuration registers back to their default values.
module n_shot_modifier_tracker_top #(
    parameter int NUM_SLOTS = nsmt_pkg::DEF_NUM_SLOTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: key_code [15:0], event_time [31:16]
    input  logic [nsmt_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser: key_pressed [0], cancel_layer_active [1]
    input  logic [nsmt_pkg::IN_USER_W-1:0]      s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: mods_to_register [7:0], mods_to_unregister [15:8]
    output logic [nsmt_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nsmt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nsmt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import nsmt_pkg::*;

    cfg_t  cfg_reg;
    evt_t  front_evt;
    evt_t  head_evt;
    logic  q_full;
    logic  q_valid;
    logic  back_pop;
    logic  in_beat;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~q_full;
    assign in_beat   = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_keys <= RST_TRIGGER_KEYS;
            cfg_reg.mod_masks    <= RST_MOD_MASKS;
            cfg_reg.max_shots    <= RST_MAX_SHOTS;
            cfg_reg.roll_flags   <= RST_ROLL_FLAGS;
            cfg_reg.cancel_keys  <= RST_CANCEL_KEYS;
            cfg_reg.extra_keys   <= RST_EXTRA_KEYS;
            cfg_reg.tap_window   <= RST_TAP_WINDOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TRIGGER_KEYS: cfg_reg.trigger_keys <= cfg_data;
                CFG_MOD_MASKS:    cfg_reg.mod_masks    <= cfg_data[31:0];
                CFG_MAX_SHOTS:    cfg_reg.max_shots    <= cfg_data[15:0];
                CFG_ROLL_FLAGS:   cfg_reg.roll_flags   <= cfg_data[3:0];
                CFG_CANCEL_KEYS:  cfg_reg.cancel_keys  <= cfg_data[47:0];
                CFG_EXTRA_KEYS:   cfg_reg.extra_keys   <= cfg_data[31:0];
                CFG_TAP_WINDOW:   cfg_reg.tap_window   <= cfg_data[15:0];
                default:          ; // drop writes past the last register
            endcase
        end
    end

    nsmt_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .cfg                 (cfg_reg),
        .key_code            (s_tdata[15:0]),
        .key_pressed         (s_tuser[0]),
        .cancel_layer_active (s_tuser[1]),
        .event_time          (s_tdata[31:16]),
        .evt                 (front_evt)
    );

    nsmt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_beat),
        .push_evt   (front_evt),
        .full       (q_full),
        .pop        (back_pop),
        .head_valid (q_valid),
        .head_evt   (head_evt)
    );

    nsmt_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .evt_valid (q_valid),
        .evt       (head_evt),
        .evt_pop   (back_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_pop_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        back_pop |-> q_valid)
        else $error("slot engine advanced with an empty queue");

    a_pop_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        back_pop |=> m_tvalid)
        else $error("processed event produced no result beat");

    a_full_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !back_pop) |=> q_full)
        else $error("queue drained without a pop");

    a_stall_keeps_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !back_pop)
        else $error("slot engine advanced while the result beat was stalled");

endmodule
